### hw/rtl/rasn_pkg.sv
// Shared types, codes and constants for the rational add/sub/normalize block.
// No dependencies; imported by rasn_core and rational_add_sub_normalize.
`timescale 1ns / 1ps
`default_nettype none

package rasn_pkg;

  localparam int DATA_WIDTH  = 32;
  localparam int PROD_W      = 2 * DATA_WIDTH;
  localparam int UNIT_W      = PROD_W + 2;
  localparam int CNT_W       = $clog2(DATA_WIDTH);
  localparam int NUM_W       = 32;
  localparam int DEN_W       = 31;
  localparam int FIELD_W     = 32;
  localparam int IN_TDATA_W  = 4 * FIELD_W;
  localparam int OUT_TDATA_W = 64;

  localparam logic [CNT_W-1:0]      CNT_LAST = CNT_W'(DATA_WIDTH - 1);
  localparam logic [DATA_WIDTH-1:0] HALF     = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  typedef enum logic [1:0] {
    KIND_NORM = 2'd0,
    KIND_ADD  = 2'd1,
    KIND_SUB  = 2'd2,
    KIND_EQ   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_ZERO_DEN = 2'd1,
    STAT_OVERFLOW = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_P,
    S_MUL_Q,
    S_MUL_D,
    S_COMBINE,
    S_GCD,
    S_DIV_N_CHK,
    S_DIV_N,
    S_DIV_D_CHK,
    S_DIV_D,
    S_FINISH,
    S_DONE
  } state_t;

  typedef struct packed {
    kind_t              kind;
    logic [FIELD_W-1:0] a_num;
    logic [FIELD_W-1:0] a_den;
    logic [FIELD_W-1:0] b_num;
    logic [FIELD_W-1:0] b_den;
  } item_t;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic             is_equal;
    status_t          status;
  } res_t;

  // two's complement magnitude, -2^(w-1) maps to 2^(w-1)
  function automatic logic [DATA_WIDTH-1:0] mag(input logic [DATA_WIDTH-1:0] v);
    logic [DATA_WIDTH-1:0] r;
    r = v[DATA_WIDTH-1] ? (~v + 1'b1) : v;
    return r;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/rasn_core.sv
// Sequencer and shared datapath: cross products, binary gcd, exact division.
// Depends on rasn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rasn_core
  import rasn_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire item_t item,
  output logic       res_valid,
  input  wire logic  res_take,
  output res_t       res
);

  state_t state, state_next;

  kind_t                 kind;
  logic [DATA_WIDTH-1:0] an, ad, bn, bd;
  logic                  neg_a, neg_b, neg;
  logic [PROD_W-1:0]     p, q, nn, dd, x, y, rem;
  logic [DATA_WIDTH-1:0] sh, qn;
  logic [CNT_W-1:0]      cnt;

  // accept-time decode
  logic [DATA_WIDTH-1:0] in_an, in_ad, in_bn, in_bd;
  logic                  zero_den, in_neg_a, in_neg_b;

  assign in_an    = item.a_num[DATA_WIDTH-1:0];
  assign in_ad    = item.a_den[DATA_WIDTH-1:0];
  assign in_bn    = item.b_num[DATA_WIDTH-1:0];
  assign in_bd    = item.b_den[DATA_WIDTH-1:0];
  assign in_neg_a = in_an[DATA_WIDTH-1] ^ in_ad[DATA_WIDTH-1];
  assign in_neg_b = in_bn[DATA_WIDTH-1] ^ in_bd[DATA_WIDTH-1];
  assign zero_den = (in_ad == '0) || ((item.kind != KIND_NORM) && (in_bd == '0));

  // shared multiplier and add/subtract unit
  logic [DATA_WIDTH-1:0] mul_a, mul_b;
  logic [PROD_W-1:0]     mul_out;
  logic [UNIT_W-1:0]     u_a, u_b, u_out, u_neg;
  logic                  u_sub, borrow, u_zero;

  assign mul_out = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign u_out   = u_sub ? (u_a - u_b) : (u_a + u_b);
  assign u_neg   = ~u_out + 1'b1;
  assign borrow  = u_out[UNIT_W-1];
  assign u_zero  = (u_out == '0);

  logic              q_neg, comb_neg;
  logic [PROD_W-1:0] comb_n;
  logic [PROD_W:0]   div_t;
  logic [DATA_WIDTH-1:0] num_v;
  logic              fit;

  assign q_neg = (kind == KIND_SUB) ? !neg_b : neg_b;

  always_comb begin
    if (!u_sub) begin
      comb_n   = u_out[PROD_W-1:0];
      comb_neg = neg_a;
    end else if (!borrow) begin
      comb_n   = u_out[PROD_W-1:0];
      comb_neg = neg_a;
    end else begin
      comb_n   = u_neg[PROD_W-1:0];
      comb_neg = q_neg;
    end
  end

  assign div_t = {rem, sh[DATA_WIDTH-1]};
  assign num_v = neg ? (~qn + 1'b1) : qn;
  assign fit   = !sh[DATA_WIDTH-1] && (neg ? (qn <= HALF) : !qn[DATA_WIDTH-1]);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (zero_den) begin
            state_next = S_DONE;
          end else if (item.kind == KIND_NORM) begin
            state_next = (in_an == '0) ? S_DONE : S_GCD;
          end else begin
            state_next = S_MUL_P;
          end
        end
      end
      S_MUL_P: state_next = S_MUL_Q;
      S_MUL_Q: state_next = (kind == KIND_EQ) ? S_COMBINE : S_MUL_D;
      S_MUL_D: state_next = S_COMBINE;
      S_COMBINE: begin
        if (kind == KIND_EQ || comb_n == '0) begin
          state_next = S_DONE;
        end else begin
          state_next = S_GCD;
        end
      end
      S_GCD: begin
        if (x[0] && y[0] && u_zero) begin
          state_next = S_DIV_N_CHK;
        end
      end
      S_DIV_N_CHK: state_next = borrow ? S_DIV_N : S_DONE;
      S_DIV_N: begin
        if (cnt == CNT_LAST) begin
          state_next = S_DIV_D_CHK;
        end
      end
      S_DIV_D_CHK: state_next = borrow ? S_DIV_D : S_DONE;
      S_DIV_D: begin
        if (cnt == CNT_LAST) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: state_next = S_DONE;
      S_DONE: begin
        if (res_take) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs and unit operand selection
  always_comb begin
    in_ready  = 1'b0;
    res_valid = 1'b0;
    mul_a     = an;
    mul_b     = bd;
    u_a       = '0;
    u_b       = '0;
    u_sub     = 1'b1;
    case (state)
      S_IDLE:  in_ready = 1'b1;
      S_MUL_P: begin
        mul_a = an;
        mul_b = bd;
      end
      S_MUL_Q: begin
        mul_a = bn;
        mul_b = ad;
      end
      S_MUL_D: begin
        mul_a = ad;
        mul_b = bd;
      end
      S_COMBINE: begin
        u_a   = UNIT_W'(p);
        u_b   = UNIT_W'(q);
        u_sub = (kind == KIND_EQ) || (neg_a != q_neg);
      end
      S_GCD: begin
        u_a = UNIT_W'(x);
        u_b = UNIT_W'(y);
      end
      S_DIV_N_CHK: begin
        u_a = UNIT_W'(nn[PROD_W-1:DATA_WIDTH]);
        u_b = UNIT_W'(x);
      end
      S_DIV_D_CHK: begin
        u_a = UNIT_W'(dd[PROD_W-1:DATA_WIDTH]);
        u_b = UNIT_W'(x);
      end
      S_DIV_N, S_DIV_D: begin
        u_a = UNIT_W'(div_t);
        u_b = UNIT_W'(x);
      end
      S_DONE: res_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          kind  <= item.kind;
          an    <= mag(in_an);
          ad    <= mag(in_ad);
          bn    <= mag(in_bn);
          bd    <= mag(in_bd);
          neg_a <= in_neg_a;
          neg_b <= in_neg_b;
          neg   <= in_neg_a;
          nn    <= PROD_W'(mag(in_an));
          dd    <= PROD_W'(mag(in_ad));
          x     <= PROD_W'(mag(in_an));
          y     <= PROD_W'(mag(in_ad));
          res.num      <= '0;
          res.den      <= DEN_W'(1);
          res.is_equal <= 1'b0;
          res.status   <= zero_den ? STAT_ZERO_DEN : STAT_OK;
        end
      end
      S_MUL_P: p  <= mul_out;
      S_MUL_Q: q  <= mul_out;
      S_MUL_D: dd <= mul_out;
      S_COMBINE: begin
        if (kind == KIND_EQ) begin
          res.is_equal <= u_zero && ((p == '0) || (neg_a == neg_b));
        end else begin
          nn  <= comb_n;
          x   <= comb_n;
          y   <= dd;
          neg <= comb_neg;
        end
      end
      S_GCD: begin
        if (!x[0] && !y[0]) begin
          x  <= x >> 1;
          y  <= y >> 1;
          nn <= nn >> 1;
          dd <= dd >> 1;
        end else if (!x[0]) begin
          x <= x >> 1;
        end else if (!y[0]) begin
          y <= y >> 1;
        end else if (!u_zero) begin
          if (!borrow) begin
            x <= u_out[PROD_W-1:0];
          end else begin
            y <= u_neg[PROD_W-1:0];
          end
        end
      end
      S_DIV_N_CHK: begin
        cnt <= '0;
        rem <= PROD_W'(nn[PROD_W-1:DATA_WIDTH]);
        sh  <= nn[DATA_WIDTH-1:0];
        if (!borrow) begin
          res.status <= STAT_OVERFLOW;
        end
      end
      S_DIV_D_CHK: begin
        cnt <= '0;
        qn  <= sh;
        rem <= PROD_W'(dd[PROD_W-1:DATA_WIDTH]);
        sh  <= dd[DATA_WIDTH-1:0];
        if (!borrow) begin
          res.status <= STAT_OVERFLOW;
        end
      end
      S_DIV_N, S_DIV_D: begin
        cnt <= cnt + 1'b1;
        rem <= borrow ? div_t[PROD_W-1:0] : u_out[PROD_W-1:0];
        sh  <= {sh[DATA_WIDTH-2:0], !borrow};
      end
      S_FINISH: begin
        if (fit) begin
          res.num <= NUM_W'($signed(num_v));
          res.den <= DEN_W'(sh);
        end else begin
          res.status <= STAT_OVERFLOW;
        end
      end
      default: ;
    endcase
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state != S_IDLE)
    else $error("item accepted but sequencer stayed idle");

  a_error_fields_cleared: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && res.status != STAT_OK |->
      res.num == '0 && res.den == DEN_W'(1) && !res.is_equal)
    else $error("error item carries non-default fields");

  a_equal_only_compare: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && res.is_equal |-> kind == KIND_EQ && res.status == STAT_OK)
    else $error("is_equal set outside a good compare");

  a_gcd_operands_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_GCD |-> x != '0 && y != '0)
    else $error("gcd operand reached zero");

  a_divisor_odd: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV_N || state == S_DIV_D |-> x[0])
    else $error("divisor is not the odd gcd part");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && !res_take |=> state == S_DONE && $stable(res))
    else $error("pending result changed before it was taken");

endmodule

`default_nettype wire

### hw/rtl/rational_add_sub_normalize.sv
// Top level: stream ports, output register and the rasn_core sequencer.
// Depends on rasn_pkg and rasn_core.
//
// Takes one item at a time: kind selects normalize a, a+b, a-b or a==b. Add and
// subtract form the exact cross products on one 32x32 multiplier, then reduce by
// a binary gcd on a shared 66-bit add/subtract unit (one shift or subtract per
// cycle) and two exact 32-step restoring divisions on that same unit. The gcd
// loop sets how long an item occupies the block; compare, a zero denominator or
// a zero result skip the gcd and the divisions. A finished result sits in the
// output register, and the next item is taken while it waits. Errors give
// res_num 0, res_den 1 and a non-zero status.
`timescale 1ns / 1ps
`default_nettype none

module rational_add_sub_normalize
  import rasn_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,  // a_num, a_den, b_num, b_den
  input  wire logic [1:0]             s_tuser,  // kind
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [OUT_TDATA_W-1:0]      m_tdata,  // res_num, res_den, is_equal
  output logic [1:0]                  m_tuser   // status
);

  item_t item;
  res_t  res;
  logic  res_valid, load;

  assign item.kind  = kind_t'(s_tuser);
  assign item.a_num = s_tdata[FIELD_W-1:0];
  assign item.a_den = s_tdata[2*FIELD_W-1:FIELD_W];
  assign item.b_num = s_tdata[3*FIELD_W-1:2*FIELD_W];
  assign item.b_den = s_tdata[4*FIELD_W-1:3*FIELD_W];

  rasn_core u_core (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .item      (item),
    .res_valid (res_valid),
    .res_take  (load),
    .res       (res)
  );

  assign load = res_valid && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {res.is_equal, res.den, res.num};
      m_tuser <= res.status;
    end
  end

endmodule

`default_nettype wire
